[rtl/pwsc_pkg.sv]
// ----------------------------------------------------------------------------
// pwsc_pkg
// Shared types, register codes and the byte slide used by the planar write
// path with slide carry.
// ----------------------------------------------------------------------------
package pwsc_pkg;

  localparam int NumPlanes = 4;

  // Graphics write modes.
  localparam logic [1:0] WMODE_0 = 2'd0;
  localparam logic [1:0] WMODE_1 = 2'd1;
  localparam logic [1:0] WMODE_2 = 2'd2;
  localparam logic [1:0] WMODE_3 = 2'd3;

  // Logic functions against the latch.
  localparam logic [1:0] LF_REPLACE = 2'd0;
  localparam logic [1:0] LF_AND     = 2'd1;
  localparam logic [1:0] LF_OR      = 2'd2;
  localparam logic [1:0] LF_XOR     = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_WRITE_MODE       = 3'd0;
  localparam logic [2:0] CFG_SHIFT_COUNT      = 3'd1;
  localparam logic [2:0] CFG_SET_RESET        = 3'd2;
  localparam logic [2:0] CFG_ENABLE_SET_RESET = 3'd3;
  localparam logic [2:0] CFG_LOGIC_FUNCTION   = 3'd4;
  localparam logic [2:0] CFG_BIT_MASK         = 3'd5;
  localparam logic [2:0] CFG_SLIDE_ENABLE     = 3'd6;
  localparam logic [2:0] CFG_SLIDE_RIGHT      = 3'd7;

  // Controls that every plane lane sees.
  typedef struct packed {
    logic [1:0] write_mode;
    logic [2:0] shift_count;
    logic       slide_right;
    logic [1:0] logic_function;
    logic [7:0] mask;
  } lane_ctrl_t;

  typedef logic [NumPlanes-1:0][7:0] plane_bytes_t;

  // Slides d by n bits and fills the vacated bits from carry byte c.
  function automatic logic [7:0] slide_byte(input logic [7:0] d, input logic [7:0] c,
                                            input logic [2:0] n, input logic right);
    logic [15:0] pair;
    logic [7:0]  res;
    if (right) begin
      pair = {c, d} >> n;
      res  = pair[7:0];
    end else begin
      pair = {d, c} << n;
      res  = pair[15:8];
    end
    return res;
  endfunction

endpackage

[rtl/pwsc_lane.sv]
// ----------------------------------------------------------------------------
// pwsc_lane
// One plane lane: latch slide for mode 1, otherwise set/reset selection,
// logic function against the latch and bit masking.
// ----------------------------------------------------------------------------
module pwsc_lane
  import pwsc_pkg::*;
(
  input  lane_ctrl_t ctrl,
  input  logic       sr_bit,
  input  logic       esr_bit,
  input  logic [7:0] latch,
  input  logic [7:0] carry,
  input  logic [7:0] slid,
  output logic [7:0] data
);

  logic [7:0] src;
  logic [7:0] rop;

  always_comb begin
    if (ctrl.write_mode == WMODE_3 || esr_bit) begin
      src = {8{sr_bit}};
    end else begin
      src = slid;
    end

    case (ctrl.logic_function)
      LF_AND:  rop = src & latch;
      LF_OR:   rop = src | latch;
      LF_XOR:  rop = src ^ latch;
      default: rop = src;
    endcase

    if (ctrl.write_mode == WMODE_1) begin
      // Mode 1 moves the latch through unchanged apart from the slide.
      data = slide_byte(latch, carry, ctrl.shift_count, ctrl.slide_right);
    end else begin
      data = (rop & ctrl.mask) | (latch & ~ctrl.mask);
    end
  end

endmodule

[rtl/pwsc_out.sv]
// ----------------------------------------------------------------------------
// pwsc_out
// Merges the lane bytes with address and strobes into one result item and
// holds it in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module pwsc_out
  import pwsc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  logic         handled,
  input  logic [17:0]  address,
  input  plane_bytes_t lane_data,
  input  logic [3:0]   strobes,
  output logic         ready,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [55:0]  m_tdata,
  output logic         m_tuser
);

  logic [55:0] packed_data;

  assign ready = !m_tvalid || m_tready;

  always_comb begin
    packed_data = {2'b00, strobes,
                   lane_data[3], lane_data[2], lane_data[1], lane_data[0],
                   address};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= packed_data;
      m_tuser <= handled;
    end
  end

endmodule

[rtl/planar_write_with_slide_carry.sv]
// ----------------------------------------------------------------------------
// planar_write_with_slide_carry
// Sliding CPU writes into four-plane display memory with carry bytes.
// ----------------------------------------------------------------------------
// Each item on the s_axis side is one CPU byte write with its latches and
// map mask. The result item on m_axis carries the four plane bytes, the
// passed-through address and the plane strobes; m_tuser is high when the
// write was handled here (slide enabled and mode 0, 1 or 3), and otherwise
// data and strobes are zero. Registers are written through cfg_we,
// cfg_index and cfg_data; the user must do so only while idle, as the
// block does not enforce it. The result is registered on acceptance. One
// item is taken per cycle while the receiver keeps up: four plane lanes
// and the shared value slide work in the accepting cycle, and for handled
// writes the carry bytes update then, so the next item sees them at once.
// Reset clears the registers, the carry bytes and the output valid. When
// the receiver stalls, the result stays in the output register and
// s_tready drops until it is taken; a new item is accepted in the same
// cycle the held result leaves.
// ----------------------------------------------------------------------------
module planar_write_with_slide_carry
  import pwsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // write_address[17:0], write_value[25:18], latch_plane0[33:26],
  // latch_plane1[41:34], latch_plane2[49:42], latch_plane3[57:50],
  // plane_enables[61:58], zero fill[63:62]
  input  logic [63:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_address[17:0], data_plane0[25:18], data_plane1[33:26],
  // data_plane2[41:34], data_plane3[49:42], plane_strobes[53:50],
  // zero fill[55:54]
  output logic [55:0] m_tdata,
  // handled[0]
  output logic        m_tuser
);

  logic [1:0] write_mode;
  logic [2:0] shift_count;
  logic [3:0] set_reset;
  logic [3:0] enable_set_reset;
  logic [1:0] logic_function;
  logic [7:0] bit_mask;
  logic       slide_enable;
  logic       slide_right;

  plane_bytes_t carry;
  plane_bytes_t latch;
  plane_bytes_t lane_data;
  plane_bytes_t out_data;

  logic [17:0] write_address;
  logic [7:0]  write_value;
  logic [3:0]  plane_enables;
  logic [7:0]  slid;
  logic        handled;
  logic        accept;
  lane_ctrl_t  ctrl;

  assign write_address = s_tdata[17:0];
  assign write_value   = s_tdata[25:18];
  assign latch[0]      = s_tdata[33:26];
  assign latch[1]      = s_tdata[41:34];
  assign latch[2]      = s_tdata[49:42];
  assign latch[3]      = s_tdata[57:50];
  assign plane_enables = s_tdata[61:58];

  assign accept  = s_tvalid && s_tready;
  assign handled = slide_enable && (write_mode != WMODE_2);
  assign slid    = slide_byte(write_value, carry[0], shift_count, slide_right);

  always_comb begin
    ctrl.write_mode     = write_mode;
    ctrl.shift_count    = shift_count;
    ctrl.slide_right    = slide_right;
    ctrl.logic_function = logic_function;
    // Mode 3 narrows the bit mask by the slid CPU value.
    ctrl.mask = (write_mode == WMODE_3) ? (bit_mask & slid) : bit_mask;
  end

  for (genvar p = 0; p < NumPlanes; p++) begin : g_lane
    pwsc_lane u_lane (
      .ctrl    (ctrl),
      .sr_bit  (set_reset[p]),
      .esr_bit (enable_set_reset[p]),
      .latch   (latch[p]),
      .carry   (carry[p]),
      .slid    (slid),
      .data    (lane_data[p])
    );
  end

  assign out_data = handled ? lane_data : '0;

  pwsc_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .handled   (handled),
    .address   (write_address),
    .lane_data (out_data),
    .strobes   (handled ? plane_enables : 4'd0),
    .ready     (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      write_mode       <= WMODE_0;
      shift_count      <= 3'd0;
      set_reset        <= 4'd0;
      enable_set_reset <= 4'd0;
      logic_function   <= LF_REPLACE;
      bit_mask         <= 8'd0;
      slide_enable     <= 1'b0;
      slide_right      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WRITE_MODE:       write_mode       <= cfg_data[1:0];
        CFG_SHIFT_COUNT:      shift_count      <= cfg_data[2:0];
        CFG_SET_RESET:        set_reset        <= cfg_data[3:0];
        CFG_ENABLE_SET_RESET: enable_set_reset <= cfg_data[3:0];
        CFG_LOGIC_FUNCTION:   logic_function   <= cfg_data[1:0];
        CFG_BIT_MASK:         bit_mask         <= cfg_data;
        CFG_SLIDE_ENABLE:     slide_enable     <= cfg_data[0];
        CFG_SLIDE_RIGHT:      slide_right      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Mode 1 keeps every latch byte as its carry; modes 0 and 3 keep only the
  // CPU value in the first carry byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      carry <= '0;
    end else if (accept && handled) begin
      if (write_mode == WMODE_1) begin
        carry <= latch;
      end else begin
        carry[0] <= write_value;
      end
    end
  end

endmodule
